/* src/ffsa_pkg.sv */
// Shared widths, codes and types of the first-fit segment allocator.
package ffsa_pkg;

    localparam int ADDR_W     = 44;
    localparam int SIZE_W     = 17;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 44;

    localparam int MAX_SEGMENTS_DEF  = 16;
    localparam int HEAP_GRANULES_DEF = 65536;
    localparam int HEAP_LENGTH_RESET = 65536;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LENGTH = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ZERO  = 3'd4;

    typedef struct packed {
        logic              op;
        logic [SIZE_W-1:0] size_granules;
        logic [ADDR_W-1:0] block_address;
    } ffsa_in_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   result_address;
        logic [STATUS_W-1:0] status;
    } ffsa_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_CHECK,
        S_RANGE,
        S_SCAN,
        S_DECIDE,
        S_MOVE,
        S_WRITE,
        S_DONE
    } ffsa_state_t;

    typedef struct packed {
        logic load;
        logic init_wr;
        logic calc_off;
        logic early_fin;
        logic scan_start;
        logic scan_step;
        logic decide;
        logic move_step;
        logic commit;
        logic out_load;
    } ffsa_cmd_t;

    typedef struct packed {
        logic init_pending;
        logic early_err;
        logic scan_fin;
        logic move_done;
        logic out_free;
    } ffsa_sts_t;

endpackage

/* src/ffsa_ctrl.sv */
// Sequencer of the allocator: steps one request through check, scan, shift and write.
module ffsa_ctrl import ffsa_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ffsa_sts_t sts,
    output ffsa_cmd_t cmd
);

    ffsa_state_t state_reg;
    ffsa_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        s_ready    = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (sts.init_pending) begin
                    state_next = S_INIT;
                end else begin
                    s_ready = 1'b1;
                    if (s_valid) begin
                        cmd.load   = 1'b1;
                        state_next = S_CHECK;
                    end
                end
            end
            S_INIT: begin
                cmd.init_wr = 1'b1;
                state_next  = S_IDLE;
            end
            S_CHECK: begin
                cmd.calc_off = 1'b1;
                state_next   = S_RANGE;
            end
            S_RANGE: begin
                if (sts.early_err) begin
                    cmd.early_fin = 1'b1;
                    state_next    = S_DONE;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_fin) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = S_MOVE;
            end
            S_MOVE: begin
                cmd.move_step = 1'b1;
                if (sts.move_done) begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                cmd.commit = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* src/ffsa_dp.sv */
// Datapath of the allocator: config registers, segment table memory, scan, shift and result.
module ffsa_dp import ffsa_pkg::*; #(
    parameter int MAX_SEGMENTS  = MAX_SEGMENTS_DEF,
    parameter int HEAP_GRANULES = HEAP_GRANULES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  ffsa_in_t              in_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ffsa_out_t             m_data,
    input  ffsa_cmd_t             cmd,
    output ffsa_sts_t             sts
);

    localparam int OFF_W = $clog2(HEAP_GRANULES);
    localparam int LEN_W = $clog2(HEAP_GRANULES + 1);
    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int HL_W  = (LEN_W < SIZE_W) ? LEN_W : SIZE_W;
    localparam int CMP_W = ((LEN_W > SIZE_W) ? LEN_W : SIZE_W) + 1;
    localparam int SUM_W = ADDR_W + 1;
    localparam int LEN_RST = (HEAP_GRANULES < HEAP_LENGTH_RESET) ?
                             HEAP_GRANULES : HEAP_LENGTH_RESET;

    // configuration
    logic [ADDR_W-1:0] heap_base_reg;
    logic [HL_W-1:0]   heap_len_reg;
    logic              init_pend_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SIZE_W-1:0] cfg_len_raw;
    logic [CMP_W-1:0]  cfg_len_clamp;

    // request
    logic              op_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [ADDR_W-1:0] block_reg;
    logic [ADDR_W-1:0] offw_reg;
    logic              borrow_reg;
    logic [SUM_W-1:0]  diff_w;
    logic [SUM_W-1:0]  end_sum;
    logic              range_err;
    logic [OFF_W-1:0]  off;
    logic [LEN_W-1:0]  size_len;
    logic [LEN_W-1:0]  end_w;

    // segment table
    logic [OFF_W-1:0]  mem_start [MAX_SEGMENTS];
    logic [LEN_W-1:0]  mem_len   [MAX_SEGMENTS];
    logic [OFF_W-1:0]  rd_start_reg;
    logic [LEN_W-1:0]  rd_len_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [OFF_W-1:0]  mem_wstart;
    logic [LEN_W-1:0]  mem_wlen;

    // scan
    logic [CNT_W-1:0]  scan_idx_reg;
    logic              pend_reg;
    logic              hit_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic [OFF_W-1:0]  prev_start_reg;
    logic [LEN_W-1:0]  prev_len_reg;
    logic [OFF_W-1:0]  cur_start_reg;
    logic [LEN_W-1:0]  cur_len_reg;
    logic              scan_hit;

    // plan
    logic                pl_wr,     pl_wr_reg;
    logic [IDX_W-1:0]    pl_addr,   pl_addr_reg;
    logic [OFF_W-1:0]    pl_start,  pl_start_reg;
    logic [LEN_W-1:0]    pl_len,    pl_len_reg;
    logic                pl_inc,    pl_inc_reg;
    logic                pl_dec,    pl_dec_reg;
    logic [STATUS_W-1:0] pl_status, status_reg;
    logic [CNT_W-1:0]    pl_src;
    logic [CNT_W-1:0]    pl_left;
    logic                pl_up;
    logic [OFF_W-1:0]    res_off_reg;
    logic [LEN_W-1:0]    prev_end;
    logic                join_prev;
    logic                join_next;
    logic [IDX_W-1:0]    pos_idx;

    // shift
    logic [CNT_W-1:0]  mv_src_reg;
    logic [CNT_W-1:0]  mv_left_reg;
    logic              mv_up_reg;
    logic              mv_pend_reg;
    logic [IDX_W-1:0]  mv_wsrc_reg;

    // result
    logic [ADDR_W-1:0] res_addr_reg;
    logic              m_valid_reg;
    ffsa_out_t         m_data_reg;

    assign cfg_len_raw = cfg_wdata[SIZE_W-1:0];

    always_comb begin
        if (cfg_len_raw == '0) begin
            cfg_len_clamp = CMP_W'(1);
        end else if (CMP_W'(cfg_len_raw) > CMP_W'(HEAP_GRANULES)) begin
            cfg_len_clamp = CMP_W'(HEAP_GRANULES);
        end else begin
            cfg_len_clamp = CMP_W'(cfg_len_raw);
        end
    end

    // any register write restarts the table from a single full-heap segment
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_base_reg <= '0;
            heap_len_reg  <= HL_W'(LEN_RST);
            init_pend_reg <= 1'b1;
            count_reg     <= CNT_W'(1);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_HEAP_BASE: begin
                    heap_base_reg <= cfg_wdata[ADDR_W-1:0];
                end
                CFG_HEAP_LENGTH: begin
                    heap_len_reg <= HL_W'(cfg_len_clamp);
                end
                default: begin
                end
            endcase
            init_pend_reg <= 1'b1;
            count_reg     <= CNT_W'(1);
        end else begin
            if (cmd.init_wr) begin
                init_pend_reg <= 1'b0;
            end
            if (cmd.commit) begin
                if (pl_inc_reg) begin
                    count_reg <= count_reg + CNT_W'(1);
                end else if (pl_dec_reg) begin
                    count_reg <= count_reg - CNT_W'(1);
                end
            end
        end
    end

    // request capture and range check
    assign diff_w    = {1'b0, block_reg} - {1'b0, heap_base_reg};
    assign end_sum   = {1'b0, offw_reg} + SUM_W'(size_reg);
    assign range_err = borrow_reg || (end_sum > SUM_W'(heap_len_reg));
    assign off       = offw_reg[OFF_W-1:0];
    assign size_len  = LEN_W'(size_reg);
    assign end_w     = LEN_W'(off) + size_len;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= in_data.op;
            size_reg  <= in_data.size_granules;
            block_reg <= in_data.block_address;
        end
        if (cmd.calc_off) begin
            offw_reg   <= diff_w[ADDR_W-1:0];
            borrow_reg <= diff_w[ADDR_W];
        end
    end

    // table memory: one write and one registered read per cycle
    assign rd_addr = cmd.move_step ? mv_src_reg[IDX_W-1:0] : scan_idx_reg[IDX_W-1:0];

    always_comb begin
        mem_we     = 1'b0;
        mem_waddr  = pl_addr_reg;
        mem_wstart = pl_start_reg;
        mem_wlen   = pl_len_reg;
        if (cmd.init_wr) begin
            mem_we     = 1'b1;
            mem_waddr  = '0;
            mem_wstart = '0;
            mem_wlen   = LEN_W'(heap_len_reg);
        end else if (cmd.move_step && mv_pend_reg) begin
            mem_we     = 1'b1;
            mem_waddr  = mv_up_reg ? mv_wsrc_reg + IDX_W'(1) : mv_wsrc_reg - IDX_W'(1);
            mem_wstart = rd_start_reg;
            mem_wlen   = rd_len_reg;
        end else if (cmd.commit && pl_wr_reg) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_start[mem_waddr] <= mem_wstart;
            mem_len[mem_waddr]   <= mem_wlen;
        end
        rd_start_reg <= mem_start[rd_addr];
        rd_len_reg   <= mem_len[rd_addr];
    end

    // scan: alloc stops at first segment long enough, free at first start above off
    always_comb begin
        if (op_reg == OP_ALLOC) begin
            scan_hit = pend_reg && (CMP_W'(rd_len_reg) >= CMP_W'(size_reg));
        end else begin
            scan_hit = pend_reg && (rd_start_reg > off);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_start) begin
            scan_idx_reg <= '0;
            pend_reg     <= 1'b0;
            hit_reg      <= 1'b0;
        end else if (cmd.scan_step) begin
            if (scan_hit) begin
                hit_reg       <= 1'b1;
                pos_reg       <= scan_idx_reg - CNT_W'(1);
                cur_start_reg <= rd_start_reg;
                cur_len_reg   <= rd_len_reg;
                pend_reg      <= 1'b0;
            end else begin
                if (pend_reg) begin
                    prev_start_reg <= rd_start_reg;
                    prev_len_reg   <= rd_len_reg;
                end
                if (scan_idx_reg == count_reg) begin
                    pos_reg  <= count_reg;
                    pend_reg <= 1'b0;
                end else begin
                    scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                    pend_reg     <= 1'b1;
                end
            end
        end
    end

    // decide what the table update is
    assign pos_idx   = pos_reg[IDX_W-1:0];
    assign prev_end  = LEN_W'(prev_start_reg) + prev_len_reg;
    assign join_prev = (pos_reg != '0) && (prev_end == LEN_W'(off));
    assign join_next = hit_reg && (LEN_W'(cur_start_reg) == end_w);

    always_comb begin
        pl_wr     = 1'b0;
        pl_addr   = pos_idx;
        pl_start  = off;
        pl_len    = size_len;
        pl_inc    = 1'b0;
        pl_dec    = 1'b0;
        pl_status = ST_OK;
        pl_src    = pos_reg + CNT_W'(1);
        pl_left   = '0;
        pl_up     = 1'b0;
        if (op_reg == OP_ALLOC) begin
            if (!hit_reg) begin
                pl_status = ST_NOFIT;
            end else if (CMP_W'(cur_len_reg) == CMP_W'(size_reg)) begin
                // exact fit: close the gap
                pl_left = count_reg - pos_reg - CNT_W'(1);
                pl_dec  = 1'b1;
            end else begin
                pl_wr    = 1'b1;
                pl_start = OFF_W'(LEN_W'(cur_start_reg) + size_len);
                pl_len   = cur_len_reg - size_len;
            end
        end else begin
            if (join_prev && join_next) begin
                pl_wr    = 1'b1;
                pl_addr  = pos_idx - IDX_W'(1);
                pl_start = prev_start_reg;
                pl_len   = prev_len_reg + size_len + cur_len_reg;
                pl_left  = count_reg - pos_reg - CNT_W'(1);
                pl_dec   = 1'b1;
            end else if (join_prev) begin
                pl_wr    = 1'b1;
                pl_addr  = pos_idx - IDX_W'(1);
                pl_start = prev_start_reg;
                pl_len   = prev_len_reg + size_len;
            end else if (join_next) begin
                pl_wr  = 1'b1;
                pl_len = cur_len_reg + size_len;
            end else if (count_reg == CNT_W'(MAX_SEGMENTS)) begin
                pl_status = ST_FULL;
            end else begin
                // open a slot at pos, moving the tail up from the top
                pl_wr   = 1'b1;
                pl_src  = count_reg - CNT_W'(1);
                pl_left = count_reg - pos_reg;
                pl_up   = 1'b1;
                pl_inc  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            pl_wr_reg    <= pl_wr;
            pl_addr_reg  <= pl_addr;
            pl_start_reg <= pl_start;
            pl_len_reg   <= pl_len;
            pl_inc_reg   <= pl_inc;
            pl_dec_reg   <= pl_dec;
            res_off_reg  <= cur_start_reg;
            mv_src_reg   <= pl_src;
            mv_left_reg  <= pl_left;
            mv_up_reg    <= pl_up;
            mv_pend_reg  <= 1'b0;
        end else if (cmd.move_step) begin
            if (mv_left_reg != '0) begin
                mv_src_reg  <= mv_up_reg ? mv_src_reg - CNT_W'(1) : mv_src_reg + CNT_W'(1);
                mv_left_reg <= mv_left_reg - CNT_W'(1);
                mv_wsrc_reg <= mv_src_reg[IDX_W-1:0];
                mv_pend_reg <= 1'b1;
            end else begin
                mv_pend_reg <= 1'b0;
            end
        end
    end

    // status and result address
    always_ff @(posedge aclk) begin
        if (cmd.early_fin) begin
            status_reg   <= (size_reg == '0) ? ST_ZERO : ST_RANGE;
            res_addr_reg <= '0;
        end else if (cmd.decide) begin
            status_reg <= pl_status;
        end else if (cmd.commit) begin
            if (status_reg == ST_OK && op_reg == OP_ALLOC) begin
                res_addr_reg <= heap_base_reg + ADDR_W'(res_off_reg);
            end else begin
                res_addr_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.result_address <= res_addr_reg;
            m_data_reg.status         <= status_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign sts.init_pending = init_pend_reg;
    assign sts.early_err    = (size_reg == '0) || (op_reg == OP_FREE && range_err);
    assign sts.scan_fin     = scan_hit || (scan_idx_reg == count_reg);
    assign sts.move_done    = (mv_left_reg == '0) && !mv_pend_reg;
    assign sts.out_free     = !m_valid_reg || m_ready;

endmodule

/* src/first_fit_segment_allocator_unit.sv */
// First-fit free-segment allocator with coalescing, granule addressed. Free space is a
// table of up to MAX_SEGMENTS segments sorted by start, held in a single-port-write,
// registered-read memory. A request reads the table entries in order, up to and
// including the first fit or the first entry past the insertion point (at most the
// segment count), then shifts the entries behind that point one by one through the
// one table port when a segment is removed or inserted; a zero-size request or an
// out-of-range free skips the scan. After reset and after every register write the
// block writes the initial full-heap segment before taking a request. One request
// is in work at a time; a new request is taken while the previous result beat still
// waits on the output register.
module first_fit_segment_allocator_unit import ffsa_pkg::*; #(
    parameter int MAX_SEGMENTS  = MAX_SEGMENTS_DEF,
    parameter int HEAP_GRANULES = HEAP_GRANULES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ffsa_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ffsa_out_t             m_data
);

    ffsa_cmd_t cmd;
    ffsa_sts_t sts;

    ffsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ffsa_dp #(
        .MAX_SEGMENTS  (MAX_SEGMENTS),
        .HEAP_GRANULES (HEAP_GRANULES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    // at most one datapath command per cycle
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("more than one datapath command active");

    // one request at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while another is in work");

    // no request before the table holds its initial segment
    a_no_accept_in_init: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !sts.init_pending)
        else $error("request taken with table init pending");

    // a result beat only appears from a finished request
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.out_load))
        else $error("result beat without a finished request");

endmodule
